// ===== src/segment_reorder_buffer_defines.svh =====
// Assertion macros for the segment reorder buffer.
// Clock clk and active-low reset rst_n are taken from the module scope.
`ifndef SEGMENT_REORDER_BUFFER_DEFINES_SVH
`define SEGMENT_REORDER_BUFFER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment reorder buffer check failed");
`define SRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment reorder buffer check failed");
`else
`define SRB_ASSERT_NOW(label, ante, cons)
`define SRB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/srb_pkg.sv =====
// Shared constants for the segment reorder buffer.
// No dependencies.
package srb_pkg;
  localparam int WINDOW_SLOTS_DEF      = 16;
  localparam int MAX_SEGMENT_BYTES_DEF = 2048;
  localparam int MAX_READ_BYTES_DEF    = 64;

  localparam logic [5:0] HEADER_RESET = 6'd14;
  localparam int SEGS_W  = 5;
  localparam int BYTES_W = 16;
  localparam int COUNT_W = 16;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [2:0] ST_BYTE_STORED = 3'd0;
  localparam logic [2:0] ST_SEG_STORED  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE   = 3'd2;
  localparam logic [2:0] ST_OUT_WINDOW  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG    = 3'd4;
  localparam logic [2:0] ST_FOUND       = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd6;
  localparam logic [2:0] ST_READ        = 3'd7;
endpackage

// ===== src/segment_reorder_buffer.sv =====
// Segment reorder buffer: top level with payload memory and read sequencer.
// Depends on srb_pkg and segment_reorder_buffer_defines.svh.
//
//  channel  ports              direction  transaction
//  in       in_valid/in_stall  input      push byte, lookup or read
//  out      out_valid/out_stall output    one status or payload byte
//  cfg      cfg_wr_en          input      header_bytes write
//
// Push and lookup: one transaction in, one result out; the block takes a new
// item once the result register has drained.
// Read: each delivered byte takes a read issue step, then a data step, and
// each empty segment dropped on the way takes a step of its own; stalls add.
// The single-port payload memory with its registered read sets the pace.
// Reset is synchronous; the payload memory and slot seq/len tables are not cleared.
// A stalled output holds the read sequencer in place; nothing is dropped.
`include "segment_reorder_buffer_defines.svh"
module segment_reorder_buffer #(
  parameter int WINDOW_SLOTS      = srb_pkg::WINDOW_SLOTS_DEF,
  parameter int MAX_SEGMENT_BYTES = srb_pkg::MAX_SEGMENT_BYTES_DEF,
  parameter int MAX_READ_BYTES    = srb_pkg::MAX_READ_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_seq,
  input  logic [7:0]  in_data_byte,
  input  logic        in_seg_last,
  input  logic [6:0]  in_request_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_out_byte,
  output logic        out_byte_valid,
  output logic        out_request_done,
  output logic        out_run_last,
  output logic [srb_pkg::SEGS_W-1:0]  out_segments_held,
  output logic [srb_pkg::BYTES_W-1:0] out_bytes_held,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data
);
  localparam int SW  = $clog2(WINDOW_SLOTS);
  localparam int LW  = $clog2(MAX_SEGMENT_BYTES + 1);
  localparam int OW  = $clog2(MAX_SEGMENT_BYTES);
  localparam int AW  = $clog2(WINDOW_SLOTS * MAX_SEGMENT_BYTES);
  localparam int RW  = $clog2(MAX_READ_BYTES + 1);
  localparam int HW  = $clog2(WINDOW_SLOTS + 1);
  localparam int CW  = srb_pkg::COUNT_W;
  localparam int BW  = srb_pkg::BYTES_W;
  localparam int SGW = srb_pkg::SEGS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  // Payload memory and slot tables
  logic [7:0]    mem [WINDOW_SLOTS*MAX_SEGMENT_BYTES];
  logic [7:0]    mem_q_r;
  logic [31:0]   slot_seq_r [WINDOW_SLOTS];
  logic [LW-1:0] slot_len_r [WINDOW_SLOTS];
  logic [WINDOW_SLOTS-1:0] slot_valid_r, slot_valid_nxt;

  logic [1:0]    state_r, state_nxt;
  logic [5:0]    hdr_r;
  logic [31:0]   exp_seq_r, exp_seq_nxt;
  logic [OW-1:0] rd_off_r, rd_off_nxt;
  logic [RW-1:0] remain_r, remain_nxt;
  logic [31:0]   asm_seq_r, asm_seq_nxt;
  logic [CW-1:0] asm_cnt_r, asm_cnt_nxt;
  logic          asm_act_r, asm_act_nxt;
  logic [SW-1:0] asm_slot_r, asm_slot_nxt;
  logic          asm_has_r, asm_has_nxt;
  logic          asm_ovf_r, asm_ovf_nxt;
  logic [HW-1:0] held_segs_r, held_segs_nxt;
  logic [BW-1:0] held_bytes_r, held_bytes_nxt;

  // Byte waiting for its run_last verdict
  logic          pend_valid_r, pend_valid_nxt;
  logic          pend_done_r, pend_done_nxt;
  logic [HW-1:0] pend_segs_r, pend_segs_nxt;
  logic [BW-1:0] pend_bytes_r, pend_bytes_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;
  // Bookkeeping of the byte in flight from memory
  logic          cur_done_r, cur_done_nxt;
  logic [HW-1:0] cur_segs_r, cur_segs_nxt;
  logic [BW-1:0] cur_bytes_r, cur_bytes_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    o_status_r, o_status_nxt;
  logic [7:0]    o_byte_r, o_byte_nxt;
  logic          o_bv_r, o_bv_nxt, o_done_r, o_done_nxt, o_last_r, o_last_nxt;
  logic [HW-1:0] o_segs_r, o_segs_nxt;
  logic [BW-1:0] o_bytes_r, o_bytes_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic          set_slot;
  logic [SW-1:0] set_idx;
  logic [LW-1:0] set_len;

  logic          in_acc, out_load;
  logic          exp_hit, seq_hit, lk_hit, free_any;
  logic [SW-1:0] exp_idx, free_idx;

  // Parallel tag compares over the window
  always_comb begin
    exp_hit  = 1'b0;
    exp_idx  = '0;
    seq_hit  = 1'b0;
    lk_hit   = 1'b0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid_r[i] && slot_seq_r[i] == exp_seq_r) begin
        exp_hit = 1'b1;
        exp_idx = SW'(i);
      end
      if (slot_valid_r[i] && slot_seq_r[i] == asm_seq_nxt) seq_hit = 1'b1;
      if (slot_valid_r[i] && slot_seq_r[i] == in_seq) lk_hit = 1'b1;
      if (!slot_valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    logic [CW-1:0] cnt, pofs, cnt1, plen;
    logic [31:0]   diff;
    logic [6:0]    want;
    logic [LW-1:0] off1;

    state_nxt      = state_r;
    slot_valid_nxt = slot_valid_r;
    exp_seq_nxt    = exp_seq_r;
    rd_off_nxt     = rd_off_r;
    remain_nxt     = remain_r;
    asm_seq_nxt    = asm_seq_r;
    asm_cnt_nxt    = asm_cnt_r;
    asm_act_nxt    = asm_act_r;
    asm_slot_nxt   = asm_slot_r;
    asm_has_nxt    = asm_has_r;
    asm_ovf_nxt    = asm_ovf_r;
    held_segs_nxt  = held_segs_r;
    held_bytes_nxt = held_bytes_r;
    pend_valid_nxt = pend_valid_r;
    pend_done_nxt  = pend_done_r;
    pend_segs_nxt  = pend_segs_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_byte_nxt  = pend_byte_r;
    cur_done_nxt   = cur_done_r;
    cur_segs_nxt   = cur_segs_r;
    cur_bytes_nxt  = cur_bytes_r;
    out_valid_nxt  = out_valid_r && out_stall;
    o_status_nxt   = o_status_r;
    o_byte_nxt     = o_byte_r;
    o_bv_nxt       = o_bv_r;
    o_done_nxt     = o_done_r;
    o_last_nxt     = o_last_r;
    o_segs_nxt     = o_segs_r;
    o_bytes_nxt    = o_bytes_r;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_re   = 1'b0;
    mem_ra   = '0;
    set_slot = 1'b0;
    set_idx  = asm_slot_r;
    set_len  = '0;
    cnt  = '0;
    pofs = '0;
    cnt1 = '0;
    plen = '0;
    diff = '0;
    want = '0;
    off1 = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            srb_pkg::MODE_PUSH: begin
              // Open assembly on the first byte of a segment
              if (!asm_act_r) begin
                asm_seq_nxt  = in_seq;
                asm_ovf_nxt  = 1'b0;
                asm_has_nxt  = free_any;
                asm_slot_nxt = free_idx;
                cnt = '0;
              end else begin
                cnt = asm_cnt_r;
              end
              if (cnt >= CW'(hdr_r)) begin
                pofs = cnt - CW'(hdr_r);
                if (pofs >= CW'(MAX_SEGMENT_BYTES)) begin
                  asm_ovf_nxt = 1'b1;
                end else if (asm_has_nxt) begin
                  mem_we = 1'b1;
                  mem_wa = AW'(asm_slot_nxt) * AW'(MAX_SEGMENT_BYTES) + AW'(pofs[OW-1:0]);
                end
              end
              cnt1 = (cnt != {CW{1'b1}}) ? cnt + 1'b1 : cnt;
              asm_cnt_nxt   = cnt1;
              out_valid_nxt = 1'b1;
              o_byte_nxt    = '0;
              o_bv_nxt      = 1'b0;
              o_done_nxt    = 1'b0;
              o_last_nxt    = 1'b1;
              o_status_nxt  = srb_pkg::ST_BYTE_STORED;
              if (!in_seg_last) begin
                asm_act_nxt = 1'b1;
              end else begin
                asm_act_nxt = 1'b0;
                plen = (cnt1 > CW'(hdr_r)) ? cnt1 - CW'(hdr_r) : '0;
                diff = asm_seq_nxt - exp_seq_r;
                if (diff >= 32'(WINDOW_SLOTS)) o_status_nxt = srb_pkg::ST_OUT_WINDOW;
                else if (seq_hit)              o_status_nxt = srb_pkg::ST_DUPLICATE;
                else if (asm_ovf_nxt)          o_status_nxt = srb_pkg::ST_TOO_LONG;
                else if (!asm_has_nxt)         o_status_nxt = srb_pkg::ST_OUT_WINDOW;
                else begin
                  set_slot = 1'b1;
                  set_idx  = asm_slot_nxt;
                  set_len  = LW'(plen);
                  slot_valid_nxt[asm_slot_nxt] = 1'b1;
                  held_segs_nxt  = held_segs_r + 1'b1;
                  held_bytes_nxt = held_bytes_r + BW'(plen);
                  o_status_nxt   = srb_pkg::ST_SEG_STORED;
                end
              end
              o_segs_nxt  = held_segs_nxt;
              o_bytes_nxt = held_bytes_nxt;
            end
            srb_pkg::MODE_LOOKUP: begin
              out_valid_nxt = 1'b1;
              o_status_nxt  = lk_hit ? srb_pkg::ST_FOUND : srb_pkg::ST_NOT_FOUND;
              o_byte_nxt    = '0;
              o_bv_nxt      = 1'b0;
              o_done_nxt    = 1'b0;
              o_last_nxt    = 1'b1;
              o_segs_nxt    = held_segs_r;
              o_bytes_nxt   = held_bytes_r;
            end
            srb_pkg::MODE_READ: begin
              // Open a request only when none is pending
              if (remain_r == '0) begin
                want = in_request_len;
                if (want == 7'd0) want = 7'd1;
                if (want > 7'(MAX_READ_BYTES)) want = 7'(MAX_READ_BYTES);
                remain_nxt = RW'(want);
              end
              pend_valid_nxt = 1'b0;
              state_nxt      = S_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (remain_r == '0 || !exp_hit) begin
          state_nxt = S_FIN;
        end else if (LW'(rd_off_r) >= slot_len_r[exp_idx]) begin
          // Drop a drained or empty segment and advance
          slot_valid_nxt[exp_idx] = 1'b0;
          held_segs_nxt = held_segs_r - 1'b1;
          exp_seq_nxt   = exp_seq_r + 32'd1;
          rd_off_nxt    = '0;
        end else begin
          mem_re = 1'b1;
          mem_ra = AW'(exp_idx) * AW'(MAX_SEGMENT_BYTES) + AW'(rd_off_r);
          off1   = LW'(rd_off_r) + 1'b1;
          remain_nxt     = remain_r - 1'b1;
          held_bytes_nxt = held_bytes_r - 1'b1;
          rd_off_nxt     = OW'(off1);
          if (off1 >= slot_len_r[exp_idx]) begin
            slot_valid_nxt[exp_idx] = 1'b0;
            held_segs_nxt = held_segs_r - 1'b1;
            exp_seq_nxt   = exp_seq_r + 32'd1;
            rd_off_nxt    = '0;
          end
          cur_done_nxt  = (remain_r == RW'(1));
          cur_segs_nxt  = held_segs_nxt;
          cur_bytes_nxt = held_bytes_nxt;
          state_nxt     = S_DATA;
        end
      end
      S_DATA: begin
        if (out_load) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            o_status_nxt  = srb_pkg::ST_READ;
            o_byte_nxt    = pend_byte_r;
            o_bv_nxt      = 1'b1;
            o_done_nxt    = pend_done_r;
            o_last_nxt    = 1'b0;
            o_segs_nxt    = pend_segs_r;
            o_bytes_nxt   = pend_bytes_r;
          end
          pend_valid_nxt = 1'b1;
          pend_byte_nxt  = mem_q_r;
          pend_done_nxt  = cur_done_r;
          pend_segs_nxt  = cur_segs_r;
          pend_bytes_nxt = cur_bytes_r;
          state_nxt      = S_RD;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          o_status_nxt   = srb_pkg::ST_READ;
          o_last_nxt     = 1'b1;
          o_byte_nxt     = pend_valid_r ? pend_byte_r : 8'd0;
          o_bv_nxt       = pend_valid_r;
          o_done_nxt     = pend_valid_r && pend_done_r;
          o_segs_nxt     = pend_valid_r ? pend_segs_r : held_segs_r;
          o_bytes_nxt    = pend_valid_r ? pend_bytes_r : held_bytes_r;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Payload memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= in_data_byte;
    if (mem_re) mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (set_slot) begin
      slot_seq_r[set_idx] <= asm_seq_nxt;
      slot_len_r[set_idx] <= set_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      hdr_r        <= srb_pkg::HEADER_RESET;
      exp_seq_r    <= 32'd1;
      rd_off_r     <= '0;
      remain_r     <= '0;
      asm_seq_r    <= '0;
      asm_cnt_r    <= '0;
      asm_act_r    <= 1'b0;
      asm_has_r    <= 1'b0;
      asm_ovf_r    <= 1'b0;
      held_segs_r  <= '0;
      held_bytes_r <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      if (cfg_wr_en) hdr_r <= cfg_wr_data;
      exp_seq_r    <= exp_seq_nxt;
      rd_off_r     <= rd_off_nxt;
      remain_r     <= remain_nxt;
      asm_seq_r    <= asm_seq_nxt;
      asm_cnt_r    <= asm_cnt_nxt;
      asm_act_r    <= asm_act_nxt;
      asm_has_r    <= asm_has_nxt;
      asm_ovf_r    <= asm_ovf_nxt;
      held_segs_r  <= held_segs_nxt;
      held_bytes_r <= held_bytes_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    asm_slot_r   <= asm_slot_nxt;
    pend_done_r  <= pend_done_nxt;
    pend_segs_r  <= pend_segs_nxt;
    pend_bytes_r <= pend_bytes_nxt;
    pend_byte_r  <= pend_byte_nxt;
    cur_done_r   <= cur_done_nxt;
    cur_segs_r   <= cur_segs_nxt;
    cur_bytes_r  <= cur_bytes_nxt;
    o_status_r   <= o_status_nxt;
    o_byte_r     <= o_byte_nxt;
    o_bv_r       <= o_bv_nxt;
    o_done_r     <= o_done_nxt;
    o_last_r     <= o_last_nxt;
    o_segs_r     <= o_segs_nxt;
    o_bytes_r    <= o_bytes_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_status_r;
  assign out_out_byte      = o_byte_r;
  assign out_byte_valid    = o_bv_r;
  assign out_request_done  = o_done_r;
  assign out_run_last      = o_last_r;
  assign out_segments_held = SGW'(o_segs_r);
  assign out_bytes_held    = o_bytes_r;

  `SRB_ASSERT_NOW(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r)
  `SRB_ASSERT_NOW(a_held_bound, 1'b1, held_segs_r <= HW'(WINDOW_SLOTS))
  `SRB_ASSERT_NEXT(a_read_data, state_r == S_RD && mem_re, state_r == S_DATA)
  `SRB_ASSERT_NOW(a_count_match, 1'b1, held_segs_r == HW'($countones(slot_valid_r)))
endmodule
